[rtl/clns_pkg.sv]
// Shared types, constants and the microcode program of the LCD nibble sequencer.
package clns_pkg;

  localparam int ROW_WIDTH = 16;
  localparam int RW_CLAMP  = (ROW_WIDTH > 16) ? 16 : ROW_WIDTH;
  localparam int CNT_W     = 4;
  localparam int PC_W      = 5;
  localparam int NSTEP     = 32;

  localparam logic [6:0] EN_MASK = 7'h10;

  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_ROW1 = 3'd1,
    OP_ROW2 = 3'd2,
    OP_ADDR = 3'd3,
    OP_CLR1 = 3'd4,
    OP_CLR2 = 3'd5,
    OP_LED  = 3'd6,
    OP_INIT = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    SRC_CONST   = 3'd0,
    SRC_CHAR_HI = 3'd1,
    SRC_CHAR_LO = 3'd2,
    SRC_ADDR_HI = 3'd3,
    SRC_ADDR_LO = 3'd4,
    SRC_LED     = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_JUMP = 2'd1,
    SEQ_LOOP = 2'd2,
    SEQ_END  = 2'd3
  } seq_e;

  // Program entry points: one per command, plus the shared space loop.
  localparam logic [PC_W-1:0] EP_CHAR  = 5'd0;
  localparam logic [PC_W-1:0] EP_ROW1  = 5'd2;
  localparam logic [PC_W-1:0] EP_ROW2  = 5'd4;
  localparam logic [PC_W-1:0] EP_ADDR  = 5'd6;
  localparam logic [PC_W-1:0] EP_CLR1  = 5'd8;
  localparam logic [PC_W-1:0] EP_CLR2  = 5'd10;
  localparam logic [PC_W-1:0] EP_SPACE = 5'd12;
  localparam logic [PC_W-1:0] EP_LED   = 5'd14;
  localparam logic [PC_W-1:0] EP_INIT  = 5'd15;

  typedef struct packed {
    src_e            src;
    logic [3:0]      nib;
    logic            rs;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    src_e       src;
    logic [3:0] nib;
    logic       rs;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] addr;
    logic [7:0] char_code;
    logic       led_on;
  } in_t;

  typedef struct packed {
    logic [6:0] word_setup;
    logic [6:0] word_strobe;
    logic [6:0] word_hold;
    logic       triple;
    logic       last;
  } out_t;

  localparam ucode_t UCODE [NSTEP] = '{
    '{SRC_CHAR_HI, 4'h0, 1'b1, SEQ_NEXT, 5'd0},      // write char
    '{SRC_CHAR_LO, 4'h0, 1'b1, SEQ_END,  5'd0},
    '{SRC_CONST,   4'h8, 1'b0, SEQ_NEXT, 5'd0},      // row 1
    '{SRC_CONST,   4'h0, 1'b0, SEQ_END,  5'd0},
    '{SRC_CONST,   4'hC, 1'b0, SEQ_NEXT, 5'd0},      // row 2
    '{SRC_CONST,   4'h0, 1'b0, SEQ_END,  5'd0},
    '{SRC_ADDR_HI, 4'h0, 1'b0, SEQ_NEXT, 5'd0},      // set address
    '{SRC_ADDR_LO, 4'h0, 1'b0, SEQ_END,  5'd0},
    '{SRC_CONST,   4'h8, 1'b0, SEQ_NEXT, 5'd0},      // clear row 1
    '{SRC_CONST,   4'h0, 1'b0, SEQ_JUMP, EP_SPACE},
    '{SRC_CONST,   4'hC, 1'b0, SEQ_NEXT, 5'd0},      // clear row 2
    '{SRC_CONST,   4'h0, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h2, 1'b1, SEQ_NEXT, 5'd0},      // space loop
    '{SRC_CONST,   4'h0, 1'b1, SEQ_LOOP, EP_SPACE},
    '{SRC_LED,     4'h0, 1'b0, SEQ_END,  5'd0},      // LED refresh
    '{SRC_CONST,   4'h3, 1'b0, SEQ_NEXT, 5'd0},      // init
    '{SRC_CONST,   4'h3, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h3, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h2, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h2, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h8, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h0, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h8, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h0, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h1, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h0, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h6, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'h0, 1'b0, SEQ_NEXT, 5'd0},
    '{SRC_CONST,   4'hC, 1'b0, SEQ_END,  5'd0},
    '{SRC_LED,     4'h0, 1'b0, SEQ_END,  5'd0},      // unused
    '{SRC_LED,     4'h0, 1'b0, SEQ_END,  5'd0},
    '{SRC_LED,     4'h0, 1'b0, SEQ_END,  5'd0}
  };

endpackage

[rtl/clns_seq.sv]
// Microcode sequencer: step counter, loop counter and branch logic over the program table.
module clns_seq
  import clns_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PC_W-1:0] entry_i,
  input  logic            advance_i,
  output logic            busy_o,
  output step_t           step_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  ucode_t           uc;
  logic             cnt_zero;

  assign uc       = UCODE[pc_q];
  assign cnt_zero = (cnt_q == '0);

  assign busy_o      = busy_q;
  assign step_o.src  = uc.src;
  assign step_o.nib  = uc.nib;
  assign step_o.rs   = uc.rs;
  assign step_o.last = busy_q && ((uc.seq == SEQ_END) || (uc.seq == SEQ_LOOP && cnt_zero));

  always_comb begin
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = entry_i;
      cnt_d  = CNT_W'(RW_CLAMP - 1);
      busy_d = 1'b1;
    end else if (advance_i && busy_q) begin
      unique case (uc.seq)
        SEQ_NEXT: pc_d = pc_q + 1'b1;
        SEQ_JUMP: pc_d = uc.target;
        SEQ_LOOP: begin
          if (cnt_zero) begin
            busy_d = 1'b0;
          end else begin
            pc_d  = uc.target;
            cnt_d = cnt_q - 1'b1;
          end
        end
        SEQ_END:  busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule

[rtl/clns_word_gen.sv]
// Datapath: picks the nibble for a step and builds the three shift-register words, or a single LED word.
module clns_word_gen
  import clns_pkg::*;
(
  input  step_t      step_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] char_code_i,
  input  logic       led_on_i,
  output out_t       word_o
);

  logic [3:0] nib;
  logic [6:0] base;

  always_comb begin
    unique case (step_i.src)
      SRC_CHAR_HI: nib = char_code_i[7:4];
      SRC_CHAR_LO: nib = char_code_i[3:0];
      SRC_ADDR_HI: nib = addr_i[7:4];
      SRC_ADDR_LO: nib = addr_i[3:0];
      default:     nib = step_i.nib;
    endcase
  end

  assign base = {~led_on_i, step_i.rs, 1'b0, nib};

  always_comb begin
    if (step_i.src == SRC_LED) begin
      // single word: LED bit only
      word_o.word_setup  = {~led_on_i, 6'b0};
      word_o.word_strobe = '0;
      word_o.word_hold   = '0;
      word_o.triple      = 1'b0;
    end else begin
      word_o.word_setup  = base;
      word_o.word_strobe = base | EN_MASK;
      word_o.word_hold   = base;
      word_o.triple      = 1'b1;
    end
    word_o.last = step_i.last;
  end

endmodule

[rtl/char_lcd_nibble_sequencer.sv]
// Top level of the character LCD nibble sequencer.
//
// Input channel: in_valid_i / in_stall_o carry one display command per beat
// (op, addr, char_code, led_on). Output channel: out_valid_o / out_stall_i
// carry one nibble result per beat: three shift-register words with EN
// low, high, low, or a single LED word for the LED refresh; last marks the
// final beat of a command.
// Each command runs a short microprogram, one step per result, one step per
// cycle while the output is taken. The first result is registered in the
// output register after the sequencer has loaded the command's entry point.
// Results per command: write char, cursor and set address 2, LED refresh 1,
// init 14, clear row 2 + 2 * RW_CLAMP (ROW_WIDTH, at most 16). The next
// command is accepted in the cycle that the last step goes out.
// A stalled output holds its beat and freezes the step counter; input is
// stalled until the last step of the running command is taken.
// Reset clears the sequencer and the output valid; nothing else needs
// clearing.
module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic            adv;
  logic            accept;
  logic            busy;
  step_t           step;
  logic [PC_W-1:0] entry;
  in_t             item_q;
  out_t            out_q, word;
  logic            out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy && !(adv && step.last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (op_e'(in_data_i.op))
      OP_CHAR: entry = EP_CHAR;
      OP_ROW1: entry = EP_ROW1;
      OP_ROW2: entry = EP_ROW2;
      OP_ADDR: entry = EP_ADDR;
      OP_CLR1: entry = EP_CLR1;
      OP_CLR2: entry = EP_CLR2;
      OP_LED:  entry = EP_LED;
      OP_INIT: entry = EP_INIT;
    endcase
  end

  clns_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .entry_i   (entry),
    .advance_i (adv),
    .busy_o    (busy),
    .step_o    (step)
  );

  clns_word_gen u_word_gen (
    .step_i      (step),
    .addr_i      (item_q.addr),
    .char_code_i (item_q.char_code),
    .led_on_i    (item_q.led_on),
    .word_o      (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (adv && busy) begin
      out_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new command only enters while the running one retires its last step
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && busy |-> adv && step.last)
    else $error("command accepted in the middle of a program");

  // single-word beats only come from the LED refresh, which is one beat long
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.triple |-> out_data_o.last)
    else $error("single-word beat not marked last");

  a_triple_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.triple |->
      out_data_o.word_strobe == (out_data_o.word_setup | EN_MASK) &&
      out_data_o.word_hold == out_data_o.word_setup &&
      (out_data_o.word_setup & EN_MASK) == 7'h00)
    else $error("nibble words out of step");

  // hold a stalled output beat until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

endmodule
